>>> hw/rtl/bspn_pkg.sv
// shared types, constants and helper functions for the battery stage pulse notifier
`timescale 1ns / 1ps
package bspn_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned NUM_STAGES = 3;

  localparam longint unsigned PULSE_LEN_US = 64'd1600000;
  localparam longint unsigned TAIL_US = 64'd300000;
  localparam longint unsigned HALF_US = PULSE_LEN_US / 2;
  // the falling ramp peaks one above half for an odd pulse length
  localparam longint unsigned UP_MAX = PULSE_LEN_US - HALF_US;
  localparam int unsigned UP_W = $clog2(UP_MAX + 1);

  // fade = floor(up * 255 / half) through an exact reciprocal multiply
  localparam longint unsigned X_MAX = 64'd255 * UP_MAX;
  localparam int unsigned X_W = $clog2(X_MAX + 1);
  localparam int unsigned H_W = $clog2(HALF_US + 1);
  localparam int unsigned REC_K = X_W + H_W;
  localparam longint unsigned REC_M = ((64'd1 << REC_K) + HALF_US - 1) / HALF_US;
  localparam int unsigned REC_M_W = $clog2(REC_M + 1);
  localparam int unsigned PROD_W = X_W + REC_M_W;
  localparam int unsigned Q_W = PROD_W - REC_K;

  localparam logic [3:0] MAX_LEVEL = 4'd10;
  localparam logic [3:0] PSTATE_DISCHARGING = 4'h0;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_TEST = 2'd1;
  localparam logic [1:0] REQ_DISCONNECT = 2'd2;

  // register indexes
  localparam logic [2:0] REG_NOTIFY_EN = 3'd0;
  localparam logic [2:0] REG_STAGE_EN = 3'd1;
  localparam logic [2:0] REG_THRESH = 3'd2;
  localparam logic [2:0] REG_COUNTS = 3'd3;
  localparam logic [2:0] REG_COLOUR0 = 3'd4;
  localparam logic [2:0] REG_COLOUR1 = 3'd5;
  localparam logic [2:0] REG_COLOUR2 = 3'd6;

  localparam logic [1:0] STAGE_NONE = 2'd3;

  typedef struct packed {
    logic        notify_en;
    logic [2:0]  stage_en;
    logic [11:0] thresh;
    logic [23:0] counts;
    logic [23:0] colour2;
    logic [23:0] colour1;
    logic [23:0] colour0;
  } cfg_t;

  typedef struct packed {
    logic            show;
    logic            want;
    logic            fade_zero;
    logic [UP_W-1:0] up;
    logic [23:0]     colour;
  } evt_res_t;

  typedef struct packed {
    logic        show;
    logic        want;
    logic [7:0]  lvl;
    logic [23:0] colour;
  } fade_res_t;

  // exact x / 255 for any product of two bytes
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> hw/rtl/bspn_cfg.sv
// configuration registers behind the apb-style port
`timescale 1ns / 1ps
module bspn_cfg import bspn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t        cfg_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx = paddr[4:2];
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_NOTIFY_EN: cfg_r.notify_en <= pwdata[0];
        REG_STAGE_EN:  cfg_r.stage_en <= pwdata[2:0];
        REG_THRESH:    cfg_r.thresh <= pwdata[11:0];
        REG_COUNTS:    cfg_r.counts <= pwdata[23:0];
        REG_COLOUR0:   cfg_r.colour0 <= pwdata[23:0];
        REG_COLOUR1:   cfg_r.colour1 <= pwdata[23:0];
        REG_COLOUR2:   cfg_r.colour2 <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NOTIFY_EN: prdata = {31'd0, cfg_r.notify_en};
      REG_STAGE_EN:  prdata = {29'd0, cfg_r.stage_en};
      REG_THRESH:    prdata = {20'd0, cfg_r.thresh};
      REG_COUNTS:    prdata = {8'd0, cfg_r.counts};
      REG_COLOUR0:   prdata = {8'd0, cfg_r.colour0};
      REG_COLOUR1:   prdata = {8'd0, cfg_r.colour1};
      REG_COLOUR2:   prdata = {8'd0, cfg_r.colour2};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/bspn_evt.sv
// event stage: notifier state update and report/pulse timing for one item
`timescale 1ns / 1ps
module bspn_evt import bspn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              fire,
  input  logic              load,
  input  logic [1:0]        req_type,
  input  logic [TIME_W-1:0] now_us,
  input  logic [7:0]        power_byte,
  input  logic [1:0]        test_stage,
  output evt_res_t          res
);

  logic              showing_r, showing_nxt;
  logic [1:0]        stage_r, stage_nxt;
  logic [7:0]        pulses_r, pulses_nxt;
  logic [TIME_W-1:0] pstart_r, pstart_nxt;
  logic              tail_r, tail_nxt;
  logic [TIME_W-1:0] tstart_r, tstart_nxt;
  logic [2:0]        fired_r, fired_nxt;
  logic              armed_r, armed_nxt;
  evt_res_t          res_r, res_nxt;

  logic [3:0]        level, pstate;
  logic [3:0]        thr [NUM_STAGES];
  logic [2:0]        above, cand, fired_clr;
  logic [1:0]        pick;
  logic [3:0]        best_thr;
  logic [TIME_W-1:0] el_pulse, el_post, el_tail;
  logic              expired, started, restart, tail_set, tail_exp;
  logic [7:0]        pl_dec;
  logic [1:0]        show_sel;
  logic [7:0]        cnt_byte;

  assign level = power_byte[3:0];
  assign pstate = power_byte[7:4];
  assign el_pulse = now_us - pstart_r;
  assign expired = el_pulse >= TIME_W'(PULSE_LEN_US);
  assign pl_dec = (pulses_r != 8'd0) ? pulses_r - 8'd1 : 8'd0;

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      thr[i] = cfg.thresh[4*i +: 4];
      above[i] = (thr[i] != 4'd0) && (level > thr[i]);
    end
    fired_clr = fired_r & ~above;
    for (int i = 0; i < NUM_STAGES; i++) begin
      cand[i] = cfg.stage_en[i] && (thr[i] != 4'd0) && !fired_clr[i] && (level <= thr[i]);
    end
    // lowest threshold wins, lower stage on a tie
    pick = STAGE_NONE;
    best_thr = 4'hF;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (cand[i] && (pick == STAGE_NONE || thr[i] < best_thr)) begin
        pick = 2'(i);
        best_thr = thr[i];
      end
    end
  end

  always_comb begin
    showing_nxt = showing_r;
    stage_nxt = stage_r;
    pulses_nxt = pulses_r;
    pstart_nxt = pstart_r;
    tail_nxt = tail_r;
    tstart_nxt = tstart_r;
    fired_nxt = fired_r;
    armed_nxt = armed_r;
    started = 1'b0;
    restart = 1'b0;
    tail_set = 1'b0;
    show_sel = 2'd0;

    case (req_type)
      REQ_TICK: begin
        if (showing_r) begin
          if (expired) begin
            restart = 1'b1;
            pstart_nxt = now_us;
            pulses_nxt = pl_dec;
            if (pl_dec == 8'd0) begin
              showing_nxt = 1'b0;
              tail_nxt = 1'b1;
              tail_set = 1'b1;
              tstart_nxt = now_us;
            end
          end
        end else if (cfg.notify_en) begin
          if (pstate != PSTATE_DISCHARGING) begin
            fired_nxt = 3'd0;
            armed_nxt = 1'b1;
          end else if (level <= MAX_LEVEL) begin
            fired_nxt = fired_clr;
            if (!armed_r) begin
              armed_nxt = 1'b1;
            end else if (pick != STAGE_NONE) begin
              fired_nxt = fired_clr | (3'b001 << pick);
              started = 1'b1;
              show_sel = pick;
            end
          end
        end
      end
      REQ_TEST: begin
        if (test_stage != STAGE_NONE) begin
          started = 1'b1;
          show_sel = test_stage;
        end
      end
      REQ_DISCONNECT: begin
        showing_nxt = 1'b0;
        pulses_nxt = 8'd0;
        tail_nxt = 1'b0;
        fired_nxt = 3'd0;
        armed_nxt = 1'b0;
      end
      default: ;
    endcase

    cnt_byte = cfg.counts[8*show_sel +: 8];
    if (started) begin
      showing_nxt = 1'b1;
      stage_nxt = show_sel;
      pulses_nxt = (cnt_byte != 8'd0) ? cnt_byte : 8'd1;
      pstart_nxt = now_us;
      tail_nxt = 1'b0;
    end

    // timing as seen after the update
    el_post = (started || restart) ? '0 : el_pulse;
    el_tail = tail_set ? '0 : now_us - tstart_r;
    tail_exp = el_tail >= TIME_W'(TAIL_US);

    res_nxt.show = showing_nxt;
    res_nxt.want = showing_nxt || (tail_nxt && !tail_exp);
    res_nxt.fade_zero = el_post >= TIME_W'(PULSE_LEN_US);
    res_nxt.up = (el_post < TIME_W'(HALF_US)) ? el_post[UP_W-1:0]
                                              : UP_W'(TIME_W'(PULSE_LEN_US) - el_post);
    case (stage_nxt)
      2'd1:    res_nxt.colour = cfg.colour1;
      2'd2:    res_nxt.colour = cfg.colour2;
      default: res_nxt.colour = cfg.colour0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      showing_r <= 1'b0;
      stage_r <= 2'd0;
      pulses_r <= 8'd0;
      pstart_r <= '0;
      tail_r <= 1'b0;
      tstart_r <= '0;
      fired_r <= 3'd0;
      armed_r <= 1'b0;
    end else if (fire) begin
      showing_r <= showing_nxt;
      stage_r <= stage_nxt;
      pulses_r <= pulses_nxt;
      pstart_r <= pstart_nxt;
      tail_r <= tail_nxt && !(tail_exp && !showing_nxt);
      tstart_r <= tstart_nxt;
      fired_r <= fired_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> hw/rtl/bspn_fade.sv
// fade stage: triangular breathing level from the ramp position
`timescale 1ns / 1ps
module bspn_fade import bspn_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  evt_res_t  evt,
  output fade_res_t res
);

  logic [X_W-1:0]    x;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q;
  fade_res_t         res_r, res_nxt;

  // up * 255 as shift and subtract, then divide by half via reciprocal
  assign x = (X_W'(evt.up) << 8) - X_W'(evt.up);
  assign prod = PROD_W'(x) * PROD_W'(REC_M);
  assign q = prod[PROD_W-1:REC_K];

  always_comb begin
    res_nxt.show = evt.show;
    res_nxt.want = evt.want;
    res_nxt.colour = evt.colour;
    if (!evt.show || evt.fade_zero) begin
      res_nxt.lvl = 8'd0;
    end else if (q > Q_W'(255)) begin
      res_nxt.lvl = 8'hFF;
    end else begin
      res_nxt.lvl = q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> hw/rtl/bspn_mix.sv
// colour stage: scales the stage colour by the fade level into the result register
`timescale 1ns / 1ps
module bspn_mix import bspn_pkg::*; (
  input  logic      clk,
  input  logic      load,
  input  fade_res_t fade,
  output logic      wants_report,
  output logic      override_active,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out
);

  logic        want_r, ovr_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic [15:0] pr, pg, pb;

  assign pr = 16'(fade.colour[23:16]) * 16'(fade.lvl);
  assign pg = 16'(fade.colour[15:8]) * 16'(fade.lvl);
  assign pb = 16'(fade.colour[7:0]) * 16'(fade.lvl);

  always_ff @(posedge clk) begin
    if (load) begin
      want_r <= fade.want;
      ovr_r <= fade.show;
      red_r <= div255(pr);
      green_r <= div255(pg);
      blue_r <= div255(pb);
    end
  end

  assign wants_report = want_r;
  assign override_active = ovr_r;
  assign red_out = red_r;
  assign green_out = green_r;
  assign blue_out = blue_r;

endmodule

>>> hw/rtl/battery_stage_pulse_notifier_top.sv
// top level of the battery stage pulse notifier
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transfer: a tick
//   with the raw battery status byte, a test request for one stage, or a
//   disconnect, each stamped with the current time in microseconds.
//   Result channel (out_valid / out_stall) returns exactly one item per event:
//   report-wanted flag, override flag and the faded stage colour.
//   Registers are written through the apb-style port (psel/penable/pwrite,
//   byte address 4*index) while no events are in flight; reads are live.
//   Pipeline: input register, event/state update, fade level, colour scaling
//   into the result register. out_valid rises once the item has passed the
//   input, event, fade and result registers in turn. One event is taken
//   every cycle unless the result stalls; the per-item state update in the
//   event stage is the only feedback path.
//   A stalled result holds in the result register; earlier stages keep
//   filling until every stage is occupied, then in_stall rises.
//   Reset (rst_n low, synchronous) empties the pipeline, clears all state and
//   all registers: no pulse, no tail, stages unfired, first reading pending.
module battery_stage_pulse_notifier_top import bspn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [TIME_W-1:0] in_now_us,
  input  logic [7:0]        in_power_byte,
  input  logic [1:0]        in_test_stage,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_wants_report,
  output logic              out_override_active,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t              cfg;
  evt_res_t          evt_res;
  fade_res_t         fade_res;

  logic              v0_r, v1_r, v2_r, v3_r;
  logic              rdy0, rdy1, rdy2, rdy3;
  logic [1:0]        req_r;
  logic [TIME_W-1:0] now_r;
  logic [7:0]        pbyte_r;
  logic [1:0]        tstage_r;

  // a stage can load when empty or when its item moves on
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign in_stall = !rdy0;
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      req_r <= in_req_type;
      now_r <= in_now_us;
      pbyte_r <= in_power_byte;
      tstage_r <= in_test_stage;
    end
  end

  bspn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bspn_evt u_evt (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (v0_r && rdy1),
    .load       (rdy1),
    .req_type   (req_r),
    .now_us     (now_r),
    .power_byte (pbyte_r),
    .test_stage (tstage_r),
    .res        (evt_res)
  );

  bspn_fade u_fade (
    .clk  (clk),
    .load (rdy2),
    .evt  (evt_res),
    .res  (fade_res)
  );

  bspn_mix u_mix (
    .clk             (clk),
    .load            (rdy3),
    .fade            (fade_res),
    .wants_report    (out_wants_report),
    .override_active (out_override_active),
    .red_out         (out_red_out),
    .green_out       (out_green_out),
    .blue_out        (out_blue_out)
  );

endmodule

>>> verif/bspn_report_checker.sv
// checker for the battery stage pulse notifier: predicts every report and compares it
`timescale 1ns / 1ps
module bspn_report_checker import bspn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [TIME_W-1:0] in_now_us,
  input  logic [7:0]        in_power_byte,
  input  logic [1:0]        in_test_stage,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_wants_report,
  input  logic              out_override_active,
  input  logic [7:0]        out_red_out,
  input  logic [7:0]        out_green_out,
  input  logic [7:0]        out_blue_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                overrides,
  output int                fires
);

  typedef struct packed {
    logic       want;
    logic       ovr;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } report_t;

  report_t expected_reports[$];

  // register copies
  logic        notify_on;
  logic [2:0]  stage_mask;
  logic [11:0] thresholds;
  logic [23:0] pulse_counts;
  logic [23:0] colours [3];

  // notifier state
  logic              pulsing;
  logic [1:0]        cur_stage;
  logic [7:0]        pulses_rem;
  logic [TIME_W-1:0] pulse_t0;
  logic              tail_on;
  logic [TIME_W-1:0] tail_t0;
  logic [2:0]        fired;
  logic              primed;

  // triangular breathing level over one pulse
  function automatic logic [7:0] fade_of(input logic [TIME_W-1:0] elapsed);
    longint unsigned half, up, v;
    half = PULSE_LEN_US / 2;
    if (elapsed >= PULSE_LEN_US || half == 0) return 8'd0;
    up = (elapsed < half) ? elapsed : PULSE_LEN_US - elapsed;
    v = up * 255 / half;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] lvl);
    int p;
    p = int'(c) * int'(lvl) / 255;
    return p[7:0];
  endfunction

  task automatic start_pulsing(input logic [1:0] s, input logic [TIME_W-1:0] now);
    pulsing = 1'b1;
    cur_stage = s;
    pulses_rem = pulse_counts[8*s +: 8];
    if (pulses_rem == 8'd0) pulses_rem = 8'd1;
    pulse_t0 = now;
    tail_on = 1'b0;
  endtask

  task automatic predict_report(input logic [1:0] req, input logic [TIME_W-1:0] now,
                                input logic [7:0] pb, input logic [1:0] ts,
                                output report_t rep);
    logic [3:0]        level;
    logic [3:0]        pstate;
    logic [3:0]        thr;
    logic [1:0]        pick;
    logic [TIME_W-1:0] elapsed;
    logic [23:0]       col;
    logic [7:0]        lvl;
    int                i;
    level = pb[3:0];
    pstate = pb[7:4];
    case (req)
      REQ_TICK: begin
        if (pulsing) begin
          elapsed = now - pulse_t0;
          if (elapsed >= PULSE_LEN_US) begin
            pulse_t0 = now;
            if (pulses_rem != 8'd0) pulses_rem = pulses_rem - 8'd1;
            if (pulses_rem == 8'd0) begin
              pulsing = 1'b0;
              tail_on = 1'b1;
              tail_t0 = now;
            end
          end
        end else if (notify_on) begin
          if (pstate != PSTATE_DISCHARGING) begin
            fired = '0;
            primed = 1'b1;
          end else if (level <= MAX_LEVEL) begin
            // a level above a threshold re-arms that stage
            for (i = 0; i < NUM_STAGES; i++) begin
              thr = thresholds[4*i +: 4];
              if (thr != 4'd0 && level > thr) fired[i] = 1'b0;
            end
            if (!primed) begin
              primed = 1'b1;
            end else begin
              // lowest threshold wins, ties go to the lower stage
              pick = STAGE_NONE;
              for (i = 0; i < NUM_STAGES; i++) begin
                thr = thresholds[4*i +: 4];
                if (stage_mask[i] && thr != 4'd0 && !fired[i] && level <= thr) begin
                  if (pick == STAGE_NONE || thr < thresholds[4*pick +: 4]) pick = 2'(i);
                end
              end
              if (pick != STAGE_NONE) begin
                fired[pick] = 1'b1;
                fires++;
                start_pulsing(pick, now);
              end
            end
          end
        end
      end
      REQ_TEST: begin
        if (ts != STAGE_NONE) start_pulsing(ts, now);
      end
      REQ_DISCONNECT: begin
        pulsing = 1'b0;
        pulses_rem = 8'd0;
        tail_on = 1'b0;
        fired = '0;
        primed = 1'b0;
      end
      default: ;
    endcase

    if (pulsing) begin
      rep.want = 1'b1;
    end else if (!tail_on) begin
      rep.want = 1'b0;
    end else begin
      elapsed = now - tail_t0;
      if (elapsed >= TAIL_US) begin
        tail_on = 1'b0;
        rep.want = 1'b0;
      end else begin
        rep.want = 1'b1;
      end
    end
    rep.ovr = pulsing;
    rep.red = 8'd0;
    rep.green = 8'd0;
    rep.blue = 8'd0;
    if (pulsing) begin
      elapsed = now - pulse_t0;
      lvl = fade_of(elapsed);
      col = colours[cur_stage];
      rep.red = scale(col[23:16], lvl);
      rep.green = scale(col[15:8], lvl);
      rep.blue = scale(col[7:0], lvl);
    end
  endtask

  always @(posedge clk) begin : watch
    report_t rep;
    report_t exp_rep;
    if (!rst_n) begin
      notify_on = 1'b0;
      stage_mask = '0;
      thresholds = '0;
      pulse_counts = '0;
      colours[0] = '0;
      colours[1] = '0;
      colours[2] = '0;
      pulsing = 1'b0;
      cur_stage = '0;
      pulses_rem = '0;
      pulse_t0 = '0;
      tail_on = 1'b0;
      tail_t0 = '0;
      fired = '0;
      primed = 1'b0;
      expected_reports.delete();
      errors = 0;
      checked = 0;
      overrides = 0;
      fires = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_NOTIFY_EN: notify_on = pwdata[0];
          REG_STAGE_EN:  stage_mask = pwdata[2:0];
          REG_THRESH:    thresholds = pwdata[11:0];
          REG_COUNTS:    pulse_counts = pwdata[23:0];
          REG_COLOUR0:   colours[0] = pwdata[23:0];
          REG_COLOUR1:   colours[1] = pwdata[23:0];
          REG_COLOUR2:   colours[2] = pwdata[23:0];
          default: ;
        endcase
      end
      // result side first so a same-edge event cannot cover a spurious result
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no event outstanding");
          errors++;
        end else begin
          exp_rep = expected_reports.pop_front();
          checked++;
          if (out_override_active) overrides++;
          if (out_wants_report !== exp_rep.want) begin
            $error("wants_report: expected %0d, got %0d", exp_rep.want, out_wants_report);
            errors++;
          end
          if (out_override_active !== exp_rep.ovr) begin
            $error("override_active: expected %0d, got %0d", exp_rep.ovr,
                   out_override_active);
            errors++;
          end
          if (out_red_out !== exp_rep.red) begin
            $error("red_out: expected %0d, got %0d", exp_rep.red, out_red_out);
            errors++;
          end
          if (out_green_out !== exp_rep.green) begin
            $error("green_out: expected %0d, got %0d", exp_rep.green, out_green_out);
            errors++;
          end
          if (out_blue_out !== exp_rep.blue) begin
            $error("blue_out: expected %0d, got %0d", exp_rep.blue, out_blue_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_report(in_req_type, in_now_us, in_power_byte, in_test_stage, rep);
        expected_reports.push_back(rep);
      end
    end
    pending <= expected_reports.size();
  end

endmodule

>>> verif/tb_battery_stage_pulse_notifier_top.sv
// testbench top for the battery stage pulse notifier: stimulus, register setup and verdict
`timescale 1ns / 1ps
module tb_battery_stage_pulse_notifier_top;
  import bspn_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES = 5;
  localparam int HOLD_CYCLES = 120;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = '0;
  logic [TIME_W-1:0] in_now_us = '0;
  logic [7:0]        in_power_byte = '0;
  logic [1:0]        in_test_stage = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_wants_report;
  logic              out_override_active;
  logic [7:0]        out_red_out;
  logic [7:0]        out_green_out;
  logic [7:0]        out_blue_out;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int errors;
  int pending;
  int checked;
  int overrides;
  int fires;

  int                send_idle = 0;
  int                recv_idle = 0;
  logic              pressure_on = 1'b0;
  logic              pressure_done = 1'b0;
  int                hold_left = 0;
  logic [TIME_W-1:0] clock_us = 48'd1000;
  int                batt_level = 10;
  int                events_sent = 0;

  battery_stage_pulse_notifier_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_now_us(in_now_us),
    .in_power_byte(in_power_byte),
    .in_test_stage(in_test_stage),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_wants_report(out_wants_report),
    .out_override_active(out_override_active),
    .out_red_out(out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out(out_blue_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  bspn_report_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_now_us(in_now_us),
    .in_power_byte(in_power_byte),
    .in_test_stage(in_test_stage),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_wants_report(out_wants_report),
    .out_override_active(out_override_active),
    .out_red_out(out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out(out_blue_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .pready(pready),
    .errors(errors),
    .pending(pending),
    .checked(checked),
    .overrides(overrides),
    .fires(fires)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (pressure_on && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic en, input logic [2:0] mask,
                                input logic [11:0] thr, input logic [23:0] counts,
                                input logic [23:0] c0, input logic [23:0] c1,
                                input logic [23:0] c2);
    reg_write(REG_NOTIFY_EN, {31'd0, en});
    reg_write(REG_STAGE_EN, {29'd0, mask});
    reg_write(REG_THRESH, {20'd0, thr});
    reg_write(REG_COUNTS, {8'd0, counts});
    reg_write(REG_COLOUR0, {8'd0, c0});
    reg_write(REG_COLOUR1, {8'd0, c1});
    reg_write(REG_COLOUR2, {8'd0, c2});
  endtask

  task automatic send_event(input logic [1:0] req, input logic [TIME_W-1:0] now,
                            input logic [7:0] pb, input logic [1:0] ts);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_now_us <= now;
    in_power_byte <= pb;
    in_test_stage <= ts;
    do @(posedge clk); while (in_stall);
    events_sent++;
  endtask

  task automatic post_event(input logic [1:0] req, input logic [TIME_W-1:0] dt,
                            input logic [7:0] pb, input logic [1:0] ts);
    clock_us = clock_us + dt;
    send_event(req, clock_us, pb, ts);
  endtask

  // mostly a discharging battery drifting down, with chargers, noise and odd times
  task automatic random_event();
    int         r;
    logic [1:0] req;
    logic [7:0] pb;
    r = $urandom_range(0, 99);
    if (r < 3) clock_us = {16'($urandom), $urandom};
    else if (r < 5) clock_us = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 600000));
    else if (r < 10) clock_us = clock_us + 48'($urandom_range(0, 3));
    else clock_us = clock_us + 48'($urandom_range(10000, 450000));
    r = $urandom_range(0, 99);
    if (r < 82) req = REQ_TICK;
    else if (r < 90) req = REQ_TEST;
    else if (r < 95) req = REQ_DISCONNECT;
    else req = REQ_NONE;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      batt_level = $urandom_range(4, 10);
      pb = {4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))};
    end else if (r < 9) begin
      pb = 8'($urandom);
    end else begin
      if ($urandom_range(0, 2) == 0 && batt_level > 0) batt_level--;
      pb = {PSTATE_DISCHARGING, 4'(batt_level)};
    end
    send_event(req, clock_us, pb, 2'($urandom_range(0, 3)));
  endtask

  // let everything in flight drain before touching registers again
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: equal thresholds on stages 0 and 1, stage 0 pulse count zero
    write_settings(1'b1, 3'b111, 12'h255, 24'h010200, 24'hFFFFFF, 24'h00FF80, 24'h123456);
    post_event(REQ_TICK, 0, 8'h39, 2'd0);          // charging arms
    post_event(REQ_DISCONNECT, 1000, 8'h00, 2'd0);
    post_event(REQ_TICK, 1000, 8'h08, 2'd0);       // first reading only arms
    post_event(REQ_TICK, 1000, 8'h0F, 2'd0);       // level out of range
    post_event(REQ_TICK, 1000, 8'h04, 2'd0);       // fires, lower stage wins the tie
    post_event(REQ_TICK, 400000, 8'h04, 2'd0);
    post_event(REQ_TICK, 399999, 8'h04, 2'd0);
    post_event(REQ_TICK, 1, 8'h04, 2'd0);          // fade peak
    post_event(REQ_TICK, 799999, 8'h04, 2'd0);
    post_event(REQ_TICK, 1, 8'h04, 2'd0);          // single pulse ends, tail starts
    post_event(REQ_NONE, 299999, 8'h00, 2'd0);
    post_event(REQ_NONE, 1, 8'h00, 2'd0);          // tail expires
    post_event(REQ_TICK, 1000, 8'h01, 2'd0);
    post_event(REQ_TEST, 1000, 8'h00, STAGE_NONE);
    post_event(REQ_TEST, 200000, 8'h00, 2'd1);
    post_event(REQ_TICK, 300000, 8'hFF, 2'd0);     // byte ignored while pulsing
    clock_us = 48'hFFFF_FFFF_FFFF;
    post_event(REQ_TICK, 0, 8'h00, 2'd3);
    post_event(REQ_NONE, 1, 8'hFF, 2'd2);          // time wraps to zero
    post_event(REQ_TICK, 1600000, 8'h00, 2'd0);
    post_event(REQ_DISCONNECT, 0, 8'h00, 2'd0);
    post_event(REQ_TICK, 1000, 8'h00, 2'd0);
    post_event(REQ_TICK, 1000, 8'h50, 2'd0);       // charging clears fired flags
    post_event(REQ_TEST, 1000, 8'hAA, 2'd2);
    post_event(REQ_TEST, 800000, 8'h55, 2'd0);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_settings(1'b1, 3'b111, 12'h369, 24'h020100,
                          24'($urandom), 24'($urandom), 24'($urandom));
        1: write_settings(1'b0, 3'b000, 12'h000, 24'hFFFFFF,
                          24'hFFFFFF, 24'h000000, 24'($urandom));
        2: write_settings(1'b1, 3'b111, 12'hAAA, 24'h030201,
                          24'($urandom), 24'($urandom), 24'($urandom));
        3: write_settings(1'b1, 3'($urandom), 12'($urandom),
                          {6'd0, 2'($urandom), 6'd0, 2'($urandom), 6'd0, 2'($urandom)},
                          24'($urandom), 24'($urandom), 24'($urandom));
        default: write_settings(1'b1, 3'b101, 12'hFFF, 24'h000000,
                                24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      endcase
      if (phase < 2) begin
        send_idle <= 23;
        recv_idle <= 57;
      end else if (phase < 4) begin
        send_idle <= 57;
        recv_idle <= 23;
      end else begin
        send_idle <= 0;
        recv_idle <= 0;
        pressure_on <= 1'b1;
      end
      @(posedge clk);
      repeat (PHASE_ITEMS) random_event();
      drain();
    end

    $display("%0d events sent under %0d register settings, %0d results checked",
             events_sent, NUM_PHASES + 1, checked);
    $display("%0d stage fires, %0d results with colour override, one long receiver hold-off",
             fires, overrides);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> battery_stage_pulse_notifier_top.f
hw/rtl/bspn_pkg.sv
hw/rtl/bspn_cfg.sv
hw/rtl/bspn_evt.sv
hw/rtl/bspn_fade.sv
hw/rtl/bspn_mix.sv
hw/rtl/battery_stage_pulse_notifier_top.sv
verif/bspn_report_checker.sv
verif/tb_battery_stage_pulse_notifier_top.sv
